FILE: design/stp_pkg.sv
package stp_pkg;

    // pool geometry: the index field is 5 bits, so at most 32 entries exist
    localparam int TimerCount = 32;
    localparam int IdxW       = 5;
    localparam int PoolSize   = (TimerCount > 32) ? 32 : TimerCount;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(PoolSize - 1);

    typedef logic [IdxW-1:0] t_idx;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_BIND  = 3'd2,
        OP_ARM   = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    // entry flag codes: free, allocated and running
    typedef enum logic [1:0] {
        FLAG_FREE  = 2'd0,
        FLAG_ALLOC = 2'd1,
        FLAG_USING = 2'd2
    } t_flag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_AOUT,
        S_TRD,
        S_TEX,
        S_TFIN
    } t_state;

    // sequencer to entry store
    typedef struct packed {
        t_idx        rd_idx;
        logic        rd_en;
        logic        flag_we;
        t_idx        flag_idx;
        t_flag       flag_val;
        t_idx        wr_idx;
        logic        tmo_we;
        logic [31:0] tmo;
        logic        qd_we;
        logic [7:0]  queue;
        logic [7:0]  data;
    } t_store_req;

    // entry store to sequencer
    typedef struct packed {
        t_flag       flag;
        logic [31:0] tmo;
        logic [7:0]  queue;
        logic [7:0]  data;
    } t_store_rsp;

    typedef struct packed {
        logic        result_kind;
        logic        alloc_ok;
        t_idx        out_timer;
        logic [7:0]  out_queue;
        logic [7:0]  out_data;
        logic [31:0] tick_total;
        logic        last;
    } t_result;

endpackage

FILE: design/stp_if.sv
interface stp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [4:0]  timer_index;
    logic [31:0] timeout_ticks;
    logic [7:0]  queue_id;
    logic [7:0]  data_byte;

    modport source (output valid, output opcode, output timer_index,
                    output timeout_ticks, output queue_id, output data_byte,
                    input ready);
    modport sink   (input valid, input opcode, input timer_index,
                    input timeout_ticks, input queue_id, input data_byte,
                    output ready);
endinterface

interface stp_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        alloc_ok;
    logic [4:0]  out_timer;
    logic [7:0]  out_queue;
    logic [7:0]  out_data;
    logic [31:0] tick_total;
    logic        last;

    modport source (output valid, output result_kind, output alloc_ok,
                    output out_timer, output out_queue, output out_data,
                    output tick_total, output last, input ready);
    modport sink   (input valid, input result_kind, input alloc_ok,
                    input out_timer, input out_queue, input out_data,
                    input tick_total, input last, output ready);
endinterface

FILE: design/stp_store.sv
module stp_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stp_pkg::t_store_req i_req,
    output stp_pkg::t_store_rsp o_rsp
);

    // flags live in flops so reset frees every entry at once
    stp_pkg::t_flag r_flag [stp_pkg::PoolSize];

    // timeout, queue and data have no reset value
    logic [31:0] r_tmo_mem   [stp_pkg::PoolSize];
    logic [7:0]  r_queue_mem [stp_pkg::PoolSize];
    logic [7:0]  r_data_mem  [stp_pkg::PoolSize];

    logic [31:0] r_rd_tmo;
    logic [7:0]  r_rd_queue;
    logic [7:0]  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < stp_pkg::PoolSize; k++) begin
                r_flag[k] <= stp_pkg::FLAG_FREE;
            end
        end else if (i_req.flag_we) begin
            r_flag[i_req.flag_idx] <= i_req.flag_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.tmo_we) begin
            r_tmo_mem[i_req.wr_idx] <= i_req.tmo;
        end
        if (i_req.qd_we) begin
            r_queue_mem[i_req.wr_idx] <= i_req.queue;
            r_data_mem[i_req.wr_idx]  <= i_req.data;
        end
        if (i_req.rd_en) begin
            r_rd_tmo   <= r_tmo_mem[i_req.rd_idx];
            r_rd_queue <= r_queue_mem[i_req.rd_idx];
            r_rd_data  <= r_data_mem[i_req.rd_idx];
        end
    end

    assign o_rsp.flag  = r_flag[i_req.rd_idx];
    assign o_rsp.tmo   = r_rd_tmo;
    assign o_rsp.queue = r_rd_queue;
    assign o_rsp.data  = r_rd_data;

endmodule

FILE: design/software_timer_pool.sv
// pool of 32 countdown timers driven by a request channel (i_req) and a
// result channel (o_rsp), both valid/ready; a request is taken when both are high
// requests: allocate, free, bind (queue id and data), arm (timeout), tick
// free, bind and arm finish in the accept cycle; i_req.ready stays high
// allocate scans flags from entry 0, one entry per cycle, and gives one result,
//   with alloc_ok low when the pool is full
// tick bumps the tick count and walks every entry, one per cycle for an entry
//   that is not running; a running entry also reads its timeout memory in
//   S_TRD, then decrements and writes back in S_TEX through the single
//   decrement/zero-compare unit
// each expired entry gives one result; the newest expiry is held back
//   so the final result of a tick carries last, a tick with no expiry gives none
// results sit in an output register, so a new request can be taken while the
//   last result waits; a stalled receiver holds the walk only when a second
//   result must be written
// reset (synchronous, active low) frees every entry, zeroes the tick count
//   and drops any pending result; timeout, queue and data are not cleared
module software_timer_pool (
    input  logic  i_clk,
    input  logic  i_rst_n,
    stp_req_if.sink   i_req,
    stp_rsp_if.source o_rsp
);

    stp_pkg::t_state     r_state, n_state;
    stp_pkg::t_idx       r_idx, n_idx;
    logic [31:0]         r_tick, n_tick;
    logic                r_alloc_ok, n_alloc_ok;

    // held-back expiry
    logic                r_pend_valid, n_pend_valid;
    stp_pkg::t_idx       r_pend_idx, n_pend_idx;
    logic [7:0]          r_pend_queue, n_pend_queue;
    logic [7:0]          r_pend_data, n_pend_data;

    // output register
    logic                r_out_valid, n_out_valid;
    stp_pkg::t_result    r_out, n_out;

    stp_pkg::t_store_req store_req;
    stp_pkg::t_store_rsp store_rsp;

    logic        accept;
    logic        out_free;
    logic        in_range;
    logic [31:0] dec_tmo;
    logic        dec_zero;

    stp_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    assign i_req.ready = (r_state == stp_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign in_range    = ({1'b0, i_req.timer_index} < 6'(stp_pkg::PoolSize));

    // shared decrement and zero compare
    assign dec_tmo  = store_rsp.tmo - 32'd1;
    assign dec_zero = (dec_tmo == 32'd0);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_tick       = r_tick;
        n_alloc_ok   = r_alloc_ok;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_queue = r_pend_queue;
        n_pend_data  = r_pend_data;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_rsp.ready;

        store_req          = '0;
        store_req.rd_idx   = r_idx;
        store_req.flag_idx = r_idx;
        store_req.flag_val = stp_pkg::FLAG_ALLOC;
        store_req.wr_idx   = r_idx;
        store_req.tmo      = dec_tmo;
        store_req.queue    = i_req.queue_id;
        store_req.data     = i_req.data_byte;

        case (r_state)
            stp_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.opcode)
                        stp_pkg::OP_ALLOC: begin
                            n_idx   = '0;
                            n_state = stp_pkg::S_ASCAN;
                        end
                        stp_pkg::OP_FREE: begin
                            store_req.flag_we  = in_range;
                            store_req.flag_idx = i_req.timer_index;
                            store_req.flag_val = stp_pkg::FLAG_FREE;
                        end
                        stp_pkg::OP_BIND: begin
                            store_req.qd_we  = in_range;
                            store_req.wr_idx = i_req.timer_index;
                        end
                        stp_pkg::OP_ARM: begin
                            store_req.flag_we  = in_range;
                            store_req.flag_idx = i_req.timer_index;
                            store_req.flag_val = stp_pkg::FLAG_USING;
                            store_req.tmo_we   = in_range;
                            store_req.wr_idx   = i_req.timer_index;
                            store_req.tmo      = i_req.timeout_ticks;
                        end
                        stp_pkg::OP_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_idx   = '0;
                            n_state = stp_pkg::S_TRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // lowest free entry search
            stp_pkg::S_ASCAN: begin
                if (store_rsp.flag == stp_pkg::FLAG_FREE) begin
                    store_req.flag_we = 1'b1;
                    n_alloc_ok        = 1'b1;
                    n_state           = stp_pkg::S_AOUT;
                end else if (r_idx == stp_pkg::LastIdx) begin
                    n_alloc_ok = 1'b0;
                    n_state    = stp_pkg::S_AOUT;
                end else begin
                    n_idx = r_idx + stp_pkg::IdxW'(1);
                end
            end

            stp_pkg::S_AOUT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.result_kind = 1'b0;
                    n_out.alloc_ok   = r_alloc_ok;
                    n_out.out_timer  = r_alloc_ok ? r_idx : '0;
                    n_out.out_queue  = '0;
                    n_out.out_data   = '0;
                    n_out.tick_total = r_tick;
                    n_out.last       = 1'b1;
                    n_state          = stp_pkg::S_IDLE;
                end
            end

            // flag check; running entries fetch their timeout
            stp_pkg::S_TRD: begin
                if (store_rsp.flag == stp_pkg::FLAG_USING) begin
                    store_req.rd_en = 1'b1;
                    n_state         = stp_pkg::S_TEX;
                end else if (r_idx == stp_pkg::LastIdx) begin
                    n_state = stp_pkg::S_TFIN;
                end else begin
                    n_idx = r_idx + stp_pkg::IdxW'(1);
                end
            end

            // decrement, write back, record expiry
            stp_pkg::S_TEX: begin
                if (!(dec_zero && r_pend_valid && !out_free)) begin
                    store_req.tmo_we = 1'b1;
                    if (dec_zero) begin
                        store_req.flag_we = 1'b1;
                        if (r_pend_valid) begin
                            n_out_valid       = 1'b1;
                            n_out.result_kind = 1'b1;
                            n_out.alloc_ok    = 1'b0;
                            n_out.out_timer   = r_pend_idx;
                            n_out.out_queue   = r_pend_queue;
                            n_out.out_data    = r_pend_data;
                            n_out.tick_total  = r_tick;
                            n_out.last        = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                        n_pend_queue = store_rsp.queue;
                        n_pend_data  = store_rsp.data;
                    end
                    if (r_idx == stp_pkg::LastIdx) begin
                        n_state = stp_pkg::S_TFIN;
                    end else begin
                        n_idx   = r_idx + stp_pkg::IdxW'(1);
                        n_state = stp_pkg::S_TRD;
                    end
                end
            end

            // release the held-back expiry as the final result
            stp_pkg::S_TFIN: begin
                if (!r_pend_valid) begin
                    n_state = stp_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = 1'b1;
                    n_out.alloc_ok    = 1'b0;
                    n_out.out_timer   = r_pend_idx;
                    n_out.out_queue   = r_pend_queue;
                    n_out.out_data    = r_pend_data;
                    n_out.tick_total  = r_tick;
                    n_out.last        = 1'b1;
                    n_pend_valid      = 1'b0;
                    n_state           = stp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = stp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stp_pkg::S_IDLE;
            r_tick       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick       <= n_tick;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_alloc_ok   <= n_alloc_ok;
        r_pend_idx   <= n_pend_idx;
        r_pend_queue <= n_pend_queue;
        r_pend_data  <= n_pend_data;
        r_out        <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out.result_kind;
    assign o_rsp.alloc_ok    = r_out.alloc_ok;
    assign o_rsp.out_timer   = r_out.out_timer;
    assign o_rsp.out_queue   = r_out.out_queue;
    assign o_rsp.out_data    = r_out.out_data;
    assign o_rsp.tick_total  = r_out.tick_total;
    assign o_rsp.last        = r_out.last;

endmodule

FILE: tb/sv/tb.sv
// keeps its own copy of the timer table and predicts the results of each
// accepted request: allocation answers and timer expiries, in order
class timer_table_model;
    stp_pkg::t_flag   flag[stp_pkg::PoolSize];
    logic [31:0]      remaining[stp_pkg::PoolSize];
    logic [7:0]       dest_queue[stp_pkg::PoolSize];
    logic [7:0]       dest_data[stp_pkg::PoolSize];
    logic [31:0]      tick_count;
    stp_pkg::t_result due_results[$];
    int               mismatches;

    function new();
        foreach (flag[i]) begin
            flag[i]       = stp_pkg::FLAG_FREE;
            remaining[i]  = '0;
            dest_queue[i] = '0;
            dest_data[i]  = '0;
        end
        tick_count = '0;
        mismatches = 0;
    endfunction

    function void apply_request(logic [2:0] op, stp_pkg::t_idx idx, logic [31:0] tmo,
                                logic [7:0] q, logic [7:0] d);
        stp_pkg::t_result answer;
        stp_pkg::t_result prev;
        bit               have_prev;
        int               found;
        case (op)
            stp_pkg::OP_ALLOC: begin
                found = -1;
                for (int i = 0; i < stp_pkg::PoolSize; i++) begin
                    if (found < 0 && flag[i] == stp_pkg::FLAG_FREE) found = i;
                end
                answer            = '0;
                answer.tick_total = tick_count;
                answer.last       = 1'b1;
                if (found >= 0) begin
                    flag[found]      = stp_pkg::FLAG_ALLOC;
                    answer.alloc_ok  = 1'b1;
                    answer.out_timer = stp_pkg::t_idx'(found);
                end
                due_results.push_back(answer);
            end
            stp_pkg::OP_FREE: flag[idx] = stp_pkg::FLAG_FREE;
            stp_pkg::OP_BIND: begin
                dest_queue[idx] = q;
                dest_data[idx]  = d;
            end
            stp_pkg::OP_ARM: begin
                remaining[idx] = tmo;
                flag[idx]      = stp_pkg::FLAG_USING;
            end
            stp_pkg::OP_TICK: begin
                tick_count = tick_count + 32'd1;
                have_prev  = 1'b0;
                prev       = '0;
                for (int i = 0; i < stp_pkg::PoolSize; i++) begin
                    if (flag[i] == stp_pkg::FLAG_USING) begin
                        remaining[i] = remaining[i] - 32'd1;
                        if (remaining[i] == 32'd0) begin
                            flag[i] = stp_pkg::FLAG_ALLOC;
                            // hold the newest expiry so the final one can carry last
                            if (have_prev) due_results.push_back(prev);
                            prev             = '0;
                            prev.result_kind = 1'b1;
                            prev.out_timer   = stp_pkg::t_idx'(i);
                            prev.out_queue   = dest_queue[i];
                            prev.out_data    = dest_data[i];
                            prev.tick_total  = tick_count;
                            have_prev        = 1'b1;
                        end
                    end
                end
                if (have_prev) begin
                    prev.last = 1'b1;
                    due_results.push_back(prev);
                end
            end
            default: ;
        endcase
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    function void match_result(stp_pkg::t_result got);
        stp_pkg::t_result want;
        if (due_results.size() == 0) begin
            report("unexpected result, out_timer", 32'hx, 32'(got.out_timer));
            return;
        end
        want = due_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        if (got.alloc_ok !== want.alloc_ok)
            report("alloc_ok", 32'(want.alloc_ok), 32'(got.alloc_ok));
        if (got.out_timer !== want.out_timer)
            report("out_timer", 32'(want.out_timer), 32'(got.out_timer));
        if (got.out_queue !== want.out_queue)
            report("out_queue", 32'(want.out_queue), 32'(got.out_queue));
        if (got.out_data !== want.out_data)
            report("out_data", 32'(want.out_data), 32'(got.out_data));
        if (got.tick_total !== want.tick_total)
            report("tick_total", want.tick_total, got.tick_total);
        if (got.last !== want.last)
            report("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module tb;

    localparam int RANDOM_OPS    = 450;
    // longest legal quiet stretch: a sender gap plus a full tick walk over
    // 32 running entries, plus the settle time at the end; taken many times over
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;

    stp_req_if req_ch();
    stp_rsp_if rsp_ch();

    software_timer_pool dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    timer_table_model pool_model = new();

    // stimulus bookkeeping
    int burst_left = 0;
    int work_ops   = 0;
    // entries whose queue and data were written at least once; only these
    // are armed, so an expiry never reads an unwritten queue or data byte
    bit bound[stp_pkg::PoolSize];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // one request: idle gap between bursts, then hold valid until taken
    task automatic issue_request(input logic [2:0] op, input stp_pkg::t_idx idx,
                                 input logic [31:0] tmo, input logic [7:0] q,
                                 input logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.timer_index   <= idx;
        req_ch.timeout_ticks <= tmo;
        req_ch.queue_id      <= q;
        req_ch.data_byte     <= d;
        do @(posedge i_clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        pool_model.apply_request(op, idx, tmo, q, d);
        if (op <= stp_pkg::OP_TICK) work_ops++;
    endtask

    task automatic bind_entry(input stp_pkg::t_idx idx, input logic [7:0] q,
                              input logic [7:0] d);
        bound[idx] = 1'b1;
        issue_request(stp_pkg::OP_BIND, idx, $urandom, q, d);
    endtask

    task automatic arm_entry(input stp_pkg::t_idx idx, input logic [31:0] tmo);
        issue_request(stp_pkg::OP_ARM, idx, tmo, 8'($urandom), 8'($urandom));
    endtask

    task automatic tick_once();
        issue_request(stp_pkg::OP_TICK, stp_pkg::t_idx'($urandom), $urandom,
                      8'($urandom), 8'($urandom));
    endtask

    // sender holds off until every predicted result has been taken;
    // always drops valid while it waits
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pool_model.due_results.size() != 0);
    endtask

    // result monitor: every accepted result goes against the oldest prediction
    always @(posedge i_clk) begin
        stp_pkg::t_result got;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.result_kind = rsp_ch.result_kind;
            got.alloc_ok    = rsp_ch.alloc_ok;
            got.out_timer   = rsp_ch.out_timer;
            got.out_queue   = rsp_ch.out_queue;
            got.out_data    = rsp_ch.out_data;
            got.tick_total  = rsp_ch.tick_total;
            got.last        = rsp_ch.last;
            pool_model.match_result(got);
        end
    end

    // receiver back-pressure: switches between always ready, coin flip,
    // mostly stalled and long stall stretches
    initial begin : rsp_stall_gen
        int mode;
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 120)) begin
                @(posedge i_clk);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom);
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (stall_left > 0) begin
                            rsp_ch.ready <= 1'b0;
                            stall_left--;
                        end else begin
                            rsp_ch.ready <= 1'b1;
                            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    // watchdog: too long without any request or result taken ends the run
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int            pick;
        int            next_pause;
        stp_pkg::t_idx idx;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= stp_pkg::OP_ALLOC;
        req_ch.timer_index   <= '0;
        req_ch.timeout_ticks <= '0;
        req_ch.queue_id      <= '0;
        req_ch.data_byte     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        issue_request(stp_pkg::OP_ALLOC, '0, '0, '0, '0);    // lowest free entry is 0
        issue_request(stp_pkg::OP_ALLOC, '0, '0, '0, '0);    // then 1
        bind_entry(stp_pkg::t_idx'(0), 8'hFF, 8'h00);
        bind_entry(stp_pkg::t_idx'(1), 8'h00, 8'hFF);
        bind_entry(stp_pkg::LastIdx, 8'hA5, 8'h5A);          // bind on a free entry
        arm_entry(stp_pkg::t_idx'(0), 32'd1);
        arm_entry(stp_pkg::t_idx'(1), 32'd1);                // two expiries on one tick
        arm_entry(stp_pkg::LastIdx, 32'd2);                  // arm on a free entry
        tick_once();
        issue_request(stp_pkg::OP_ALLOC, '0, '0, '0, '0);    // takes entry 2; the running top entry is not free
        tick_once();                                         // top entry back to allocated
        arm_entry(stp_pkg::t_idx'(0), 32'd0);                // zero wraps, never expires here
        arm_entry(stp_pkg::t_idx'(1), 32'hFFFF_FFFF);
        arm_entry(stp_pkg::t_idx'(1), 32'd3);                // reload of a running timer
        repeat (3) tick_once();
        issue_request(stp_pkg::OP_FREE, stp_pkg::t_idx'(0), '0, '0, '0); // free a running entry
        issue_request(stp_pkg::OP_ALLOC, '0, '0, '0, '0);
        // unknown opcodes do nothing
        issue_request(3'd5, stp_pkg::t_idx'(2), 32'd9, 8'd1, 8'd2);
        issue_request(3'd6, stp_pkg::LastIdx, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        issue_request(3'd7, stp_pkg::LastIdx, 32'd1, 8'h80, 8'h01);
        issue_request(stp_pkg::OP_FREE, stp_pkg::LastIdx, '0, '0, '0);
        tick_once();                                         // nothing running that expires
        drain_results();

        // random part: mostly bind/arm/tick traffic with short timeouts so
        // expiries pile up, allocations that fill the pool, frees, long or
        // zero timeouts and some noise
        work_ops   = 0;
        next_pause = $urandom_range(60, 140);
        while (work_ops < RANDOM_OPS) begin
            if (work_ops >= next_pause) begin
                drain_results();
                next_pause = work_ops + $urandom_range(60, 140);
            end
            pick = $urandom_range(0, 99);
            idx  = stp_pkg::t_idx'($urandom_range(0, stp_pkg::PoolSize - 1));
            if (pick < 25) begin
                issue_request(stp_pkg::OP_ALLOC, idx, $urandom, 8'($urandom), 8'($urandom));
            end else if (pick < 50) begin
                bind_entry(idx, 8'($urandom), 8'($urandom));
                arm_entry(idx, $urandom_range(1, 8));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) tick_once();
            end else if (pick < 83) begin
                issue_request(stp_pkg::OP_FREE, idx, $urandom, 8'($urandom), 8'($urandom));
            end else if (pick < 88) begin
                if (!bound[idx]) bind_entry(idx, 8'($urandom), 8'($urandom));
                arm_entry(idx, $urandom_range(1, 20));
            end else if (pick < 92) begin
                // timeouts that outlast the run, zero included
                if (!bound[idx]) bind_entry(idx, 8'($urandom), 8'($urandom));
                arm_entry(idx, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
            end else if (pick < 95) begin
                bind_entry(idx, 8'($urandom), 8'($urandom));
            end else begin
                issue_request(3'($urandom_range(5, 7)), idx, $urandom,
                              8'($urandom), 8'($urandom));
            end
        end

        // wind down: all results in, then room for a trailing tick walk
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pool_model.mismatches == 0 && pool_model.due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
